// ===== src/rmd_pkg.sv =====
// Shared types, codes and constants of the record-marking deframer.
package rmd_pkg;

	localparam int MaxMsgW = 25;
	localparam int LenW    = 31;
	localparam int SumW    = 32;
	localparam int CfgIdxW = 1;
	localparam int QDepth  = 4;
	localparam int QPtrW   = 2;
	localparam int QCntW   = 3;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MAX_MSG = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_SNIFF   = 1'b1;

	localparam logic [MaxMsgW-1:0] MAX_MSG_RESET = 25'd65536;

	// Method texts checked when sniffing
	localparam logic [31:0] TXT_GET  = 32'h4745_5420;
	localparam logic [31:0] TXT_PUT  = 32'h5055_5420;
	localparam logic [31:0] TXT_POST = 32'h504f_5354;
	localparam logic [31:0] TXT_DELE = 32'h4445_4c45;
	localparam logic [31:0] TXT_HEAD = 32'h4845_4144;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_END_MARK = 2'd1,
		KIND_TOO_BIG  = 2'd2,
		KIND_REST     = 2'd3
	} rmd_kind_t;

	typedef struct packed {
		rmd_kind_t         kind;
		logic [7:0]        data;
		logic              eom;
		logic [LenW-1:0]   bad_len;
	} rmd_item_t;

	function automatic logic is_method_text(input logic [31:0] w);
		return (w == TXT_GET) || (w == TXT_PUT) || (w == TXT_POST) ||
			(w == TXT_DELE) || (w == TXT_HEAD);
	endfunction

endpackage

// ===== src/rmd_front.sv =====
// Front part: header collection, body counting, size check and result building.
module rmd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rmd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rmd_pkg::MaxMsgW-1:0]   cfg_wdata,
	input  logic                          take,
	input  logic [7:0]                    stream_byte,
	output logic                          res_valid,
	output rmd_pkg::rmd_item_t            res_item
);
	import rmd_pkg::*;

	logic [MaxMsgW-1:0] max_q;
	logic               sniff_q;
	logic [1:0]         hdr_cnt_q;
	logic [23:0]        held_q;
	logic [LenW-1:0]    left_q;
	logic               in_body_q;
	logic [MaxMsgW-1:0] total_q;
	logic               final_q;
	logic               halted_q;

	logic [31:0]        word;
	logic [LenW-1:0]    len;
	logic [SumW-1:0]    sum;
	logic               over;
	logic               last_body;

	// Assemble header word and check the running total against the limit
	always_comb begin
		word      = {held_q, stream_byte};
		len       = word[LenW-1:0];
		sum       = {{(SumW-MaxMsgW){1'b0}}, total_q} + {{(SumW-LenW){1'b0}}, len};
		over      = sum > {{(SumW-MaxMsgW){1'b0}}, max_q};
		last_body = (left_q == {{(LenW-1){1'b0}}, 1'b1});
	end

	// Build the result of the byte being taken
	always_comb begin
		res_valid        = 1'b0;
		res_item.kind    = KIND_PAYLOAD;
		res_item.data    = 8'd0;
		res_item.eom     = 1'b0;
		res_item.bad_len = '0;
		if (take && !halted_q) begin
			if (in_body_q) begin
				res_valid     = 1'b1;
				res_item.data = stream_byte;
				res_item.eom  = last_body && final_q;
			end else if (hdr_cnt_q == 2'd3) begin
				if (over) begin
					res_valid        = 1'b1;
					res_item.kind    = (sniff_q && is_method_text(word)) ?
						KIND_REST : KIND_TOO_BIG;
					res_item.bad_len = len;
				end else if (len == '0 && word[31]) begin
					res_valid     = 1'b1;
					res_item.kind = KIND_END_MARK;
					res_item.eom  = 1'b1;
				end
			end
		end
	end

	// Hold configuration and advance framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= MAX_MSG_RESET;
			sniff_q   <= 1'b0;
			hdr_cnt_q <= 2'd0;
			held_q    <= 24'd0;
			left_q    <= '0;
			in_body_q <= 1'b0;
			total_q   <= '0;
			final_q   <= 1'b0;
			halted_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_MSG: max_q   <= cfg_wdata;
					REG_SNIFF:   sniff_q <= cfg_wdata[0];
					default:     ;
				endcase
			end
			if (take && !halted_q) begin
				if (in_body_q) begin
					left_q <= left_q - {{(LenW-1){1'b0}}, 1'b1};
					if (last_body) begin
						in_body_q <= 1'b0;
						if (final_q) begin
							total_q <= '0;
						end
					end
				end else if (hdr_cnt_q != 2'd3) begin
					held_q    <= {held_q[15:0], stream_byte};
					hdr_cnt_q <= hdr_cnt_q + 2'd1;
				end else begin
					hdr_cnt_q <= 2'd0;
					held_q    <= 24'd0;
					if (over) begin
						halted_q <= 1'b1;
					end else begin
						final_q <= word[31];
						if (len == '0) begin
							if (word[31]) begin
								total_q <= '0;
							end
						end else begin
							total_q   <= sum[MaxMsgW-1:0];
							left_q    <= len;
							in_body_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// A body in progress always has bytes left
	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (left_q != '0))
		else $error("body active with no bytes left");
	// Once halted, nothing more is produced
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_valid)
		else $error("result produced while halted");
	// The accepted total never passes the limit
	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!halted_q && !$past(cfg_we)) |-> (total_q <= max_q || $past(total_q) == total_q))
		else $error("message total above limit");

endmodule

// ===== src/rmd_queue.sv =====
// Short result queue between the front and back parts.
module rmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  rmd_pkg::rmd_item_t wr_item,
	input  logic               rd_en,
	output rmd_pkg::rmd_item_t rd_item,
	output logic               q_empty,
	output logic               q_full
);
	import rmd_pkg::*;

	rmd_item_t         slot_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  cnt_q;

	assign rd_item = slot_q[rd_ptr_q];
	assign q_empty = (cnt_q == '0);
	assign q_full  = (cnt_q == QCntW'(QDepth));

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + QCntW'(1);
				2'b01:   cnt_q <= cnt_q - QCntW'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full))
		else $error("write into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && q_empty))
		else $error("read from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue count out of range");

endmodule

// ===== src/rmd_back.sv =====
// Back part: output register that presents results to the consumer.
module rmd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  rmd_pkg::rmd_item_t q_item,
	output logic               q_rd,
	input  logic               pop,
	output logic               out_valid,
	output rmd_pkg::rmd_item_t out_item
);
	import rmd_pkg::*;

	logic      valid_q;
	rmd_item_t item_q;

	assign q_rd      = !q_empty && (!valid_q || pop);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	// Refill the output register when it is free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || pop) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
	end

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_q && !q_empty) |=> valid_q)
		else $error("output register not refilled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(item_q)))
		else $error("waiting result lost or changed");
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && item_q.kind != KIND_PAYLOAD) |-> (item_q.data == 8'd0))
		else $error("non-payload result carries data");

endmodule

// ===== src/rpc_record_mark_deframer_core.sv =====
// Top level of the RPC record-marking deframer.
// A result is written to the result queue, then to the output register.
// Throughput: one byte per cycle; a four-entry result queue and an output register
// keep the input flowing while results wait to be popped, until the queue holds four.
// Reset (arst_n low, asynchronous): limit 65536, sniffing off, expecting a header,
// queue and output empty.
module rpc_record_mark_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rmd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rmd_pkg::MaxMsgW-1:0]   cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    stream_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    result_kind,
	output logic [7:0]                    payload_byte,
	output logic                          end_of_message,
	output logic [rmd_pkg::LenW-1:0]      bad_record_length
);
	import rmd_pkg::*;

	logic      take;
	logic      res_valid;
	rmd_item_t res_item;
	rmd_item_t q_item;
	logic      q_empty;
	logic      q_full;
	logic      q_rd;
	logic      out_valid;
	rmd_item_t out_item;

	// Accept a transaction whenever the queue has room
	assign full = q_full;
	assign take = push && !q_full;

	rmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.take        (take),
		.stream_byte (stream_byte),
		.res_valid   (res_valid),
		.res_item    (res_item)
	);

	rmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_item (res_item),
		.rd_en   (q_rd),
		.rd_item (q_item),
		.q_empty (q_empty),
		.q_full  (q_full)
	);

	rmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_rd      (q_rd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign empty             = !out_valid;
	assign result_kind       = out_item.kind;
	assign payload_byte      = out_item.data;
	assign end_of_message    = out_item.eom;
	assign bad_record_length = out_item.bad_len;

endmodule

// ===== tb/testbench.sv =====
// Testbench for the RPC record-marking deframer: stream stimulus, prediction and checking.
`timescale 1ns / 100ps

module testbench;
	import rmd_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [MaxMsgW-1:0]  cfg_wdata;
	logic                push;
	logic                full;
	logic [7:0]          stream_byte;
	logic                empty;
	logic                pop;
	logic [1:0]          result_kind;
	logic [7:0]          payload_byte;
	logic                end_of_message;
	logic [LenW-1:0]     bad_record_length;

	rpc_record_mark_deframer_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.push              (push),
		.full              (full),
		.stream_byte       (stream_byte),
		.empty             (empty),
		.pop               (pop),
		.result_kind       (result_kind),
		.payload_byte      (payload_byte),
		.end_of_message    (end_of_message),
		.bad_record_length (bad_record_length)
	);

	// Deframer state as predicted by the testbench
	logic [MaxMsgW-1:0] lim_bytes;
	bit                 sniff_on;
	logic [1:0]         hdr_count;
	logic [23:0]        hdr_hold;
	logic [LenW-1:0]    body_left;
	bit                 in_body;
	logic [MaxMsgW-1:0] msg_total;
	bit                 last_frag;
	bit                 stopped;

	rmd_item_t   expected_results[$];
	int          bytes_sent;
	int          err_count;
	bit          idle_on;
	logic [31:0] method_words [5];

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		#5000000;
		$display("rpc_record_mark_deframer_core verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
		err_count++;
	endtask

	// Predict the result of one accepted stream byte; return 1 when one is due
	function automatic bit deframe_byte(input logic [7:0] b, output rmd_item_t res);
		logic [31:0]     word;
		logic [LenW-1:0] flen;
		logic [32:0]     sum;
		res = '0;
		if (stopped)
			return 1'b0;
		if (in_body) begin
			body_left = body_left - 1'b1;
			res.kind = KIND_PAYLOAD;
			res.data = b;
			if (body_left == '0) begin
				in_body = 1'b0;
				if (last_frag) begin
					res.eom = 1'b1;
					msg_total = '0;
				end
			end
			return 1'b1;
		end
		if (hdr_count < 2'd3) begin
			hdr_hold = {hdr_hold[15:0], b};
			hdr_count++;
			return 1'b0;
		end
		word = {hdr_hold, b};
		flen = word[30:0];
		sum = {8'd0, msg_total} + {2'd0, flen};
		hdr_count = '0;
		hdr_hold = '0;
		if (sum > {8'd0, lim_bytes}) begin
			stopped = 1'b1;
			res.kind = (sniff_on && (word == TXT_GET || word == TXT_PUT || word == TXT_POST ||
				word == TXT_DELE || word == TXT_HEAD)) ? KIND_REST : KIND_TOO_BIG;
			res.bad_len = flen;
			return 1'b1;
		end
		last_frag = word[31];
		if (flen == '0) begin
			if (last_frag) begin
				msg_total = '0;
				res.kind = KIND_END_MARK;
				res.eom = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		msg_total = sum[MaxMsgW-1:0];
		body_left = flen;
		in_body = 1'b1;
		return 1'b0;
	endfunction

	// Send one byte and predict its result once the transaction completes
	task automatic send_byte(input logic [7:0] b);
		rmd_item_t res;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		if (deframe_byte(b, res))
			expected_results.insert(expected_results.size(), res);
	endtask

	// Send a header followed by random body bytes
	task automatic send_fragment(input bit is_last, input logic [LenW-1:0] flen);
		logic [31:0] word;
		word = {is_last, flen};
		for (int i = 3; i >= 0; i--)
			send_byte(word[i*8 +: 8]);
		for (int i = 0; i < flen; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Drop push, wait for every expected result, then let no-result bytes settle
	task automatic finish_input();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaxMsgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_MSG)
			lim_bytes = val;
		else
			sniff_on = val[0];
		@(posedge clk);
	endtask

	// Single-byte message, empty middle and last fragments, two-fragment message
	task automatic test_basic_fragments();
		send_byte(8'h80); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
		send_byte(8'h00);
		send_fragment(1'b0, '0);
		send_fragment(1'b1, '0);
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h02);
		send_byte(8'hff); send_byte(8'h55);
		send_byte(8'h80); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
		send_byte(8'haa);
		finish_input();
	endtask

	// Run well-formed traffic that stays within the limit
	task automatic run_traffic_phase(input logic [MaxMsgW-1:0] lim, input bit sniff,
		input int nbytes);
		int stop_at;
		int budget;
		int flen;
		int pick;
		write_reg(REG_MAX_MSG, lim);
		write_reg(REG_SNIFF, {24'($urandom), sniff});
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at) begin
			budget = int'(lim_bytes) - int'(msg_total);
			pick = $urandom_range(0, 9);
			if (budget == 0 || pick == 0)
				flen = 0;
			else if (pick == 1 && budget <= 64)
				flen = budget;
			else
				flen = $urandom_range(1, (budget < 24) ? budget : 24);
			send_fragment($urandom_range(0, 2) == 0, LenW'(flen));
		end
		// Close an open message so the next limit starts from zero
		if (msg_total != '0)
			send_fragment(1'b1, '0);
		finish_input();
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(25'd1, 1'b0, 200);
		run_traffic_phase(25'h1ff_ffff, 1'b1, 220);
		run_traffic_phase(25'd16777216, 1'b0, 220);
		run_traffic_phase(MaxMsgW'($urandom_range(1, 40)), 1'b1, 220);
		run_traffic_phase(25'd0, 1'b0, 120);
		run_traffic_phase(MAX_MSG_RESET, 1'b1, 220);
		run_traffic_phase(MaxMsgW'($urandom_range(2, 200)), 1'b0, 220);
		idle_on = 1'b0;
		run_traffic_phase(MaxMsgW'($urandom_range(1, 25'h1ff_ffff)), 1'b1, 220);
	endtask

	// Trigger one oversize report, then check that the block stays silent
	task automatic test_oversize_halt();
		logic [MaxMsgW-1:0] lim;
		logic [31:0]        word;
		int                 k;
		case ($urandom_range(0, 3))
			0: begin
				write_reg(REG_SNIFF, 25'd1);
				word = method_words[3'($urandom_range(0, 4))];
			end
			1: begin
				write_reg(REG_SNIFF, 25'd0);
				word = method_words[3'($urandom_range(0, 4))];
			end
			2: begin
				lim = MaxMsgW'($urandom_range(1, 25'h1ff_ffff));
				write_reg(REG_MAX_MSG, lim);
				write_reg(REG_SNIFF, 25'd1);
				word = {1'($urandom), 31'($urandom_range(lim + 1, 32'h7fff_ffff))};
			end
			default: begin
				// Exceed the limit by one with data already counted in the message
				lim = MaxMsgW'($urandom_range(2, 64));
				write_reg(REG_MAX_MSG, lim);
				write_reg(REG_SNIFF, {24'd0, 1'($urandom)});
				k = $urandom_range(1, lim - 1);
				send_fragment(1'b0, LenW'(k));
				word = {1'($urandom), 31'(lim - k + 1)};
			end
		endcase
		for (int i = 3; i >= 0; i--)
			send_byte(word[i*8 +: 8]);
		repeat (20)
			send_byte(8'($urandom_range(0, 255)));
		finish_input();
	endtask

	// Pop results with random stalls
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// Compare each popped result with the oldest expectation
	always @(posedge clk) begin : check_results
		rmd_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result kind", result_kind, 0);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (result_kind !== want.kind)
					report_mismatch("result_kind", result_kind, want.kind);
				if (payload_byte !== want.data)
					report_mismatch("payload_byte", payload_byte, want.data);
				if (end_of_message !== want.eom)
					report_mismatch("end_of_message", end_of_message, want.eom);
				if (bad_record_length !== want.bad_len)
					report_mismatch("bad_record_length", bad_record_length, want.bad_len);
			end
		end
	end

	initial begin
		push <= 1'b0;
		stream_byte <= 8'd0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MAX_MSG;
		cfg_wdata <= '0;
		arst_n = 1'b0;
		method_words = '{TXT_GET, TXT_PUT, TXT_POST, TXT_DELE, TXT_HEAD};
		lim_bytes = MAX_MSG_RESET;
		sniff_on = 1'b0;
		hdr_count = '0;
		hdr_hold = '0;
		body_left = '0;
		in_body = 1'b0;
		msg_total = '0;
		last_frag = 1'b0;
		stopped = 1'b0;
		bytes_sent = 0;
		err_count = 0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_fragments();
		test_random_traffic();
		test_oversize_halt();

		if (err_count == 0 && expected_results.size() == 0)
			$display("rpc_record_mark_deframer_core verification clean");
		else
			$display("rpc_record_mark_deframer_core verification failed");
		$finish;
	end

endmodule
